FILE: design/sdt_pkg.sv
// shared constants and types for the stereo depth triangulation block
`timescale 1ns / 1ps

package sdt_pkg;

	localparam int IMAGE_WIDTH  = 640;
	localparam int IMAGE_HEIGHT = 480;

	localparam int RAW_W  = 32;
	localparam int DISP_W = 12;
	localparam int PIX_W  = 12;
	localparam int OFF_W  = PIX_W + 1;
	localparam int LAT_W  = 24;
	localparam int INR_W  = 17;
	localparam int DEP_W  = 25;
	localparam int POS_W  = 32;

	localparam logic [RAW_W-1:0] DEPTH_SCALE_RST   = 32'd235929600;
	localparam logic [LAT_W-1:0] LATERAL_SCALE_RST = 24'd69905;
	localparam logic [INR_W-1:0] INERTIA_RST       = 17'd32768;
	localparam logic [DEP_W-1:0] DEPTH_MIN_RST     = 25'd327680;
	localparam logic [DEP_W-1:0] DEPTH_MAX_RST     = 25'd19660800;
	localparam logic [DEP_W-1:0] LAST_DEPTH_RST    = 25'd13107200;
	localparam logic [INR_W-1:0] INERTIA_ONE       = 17'd65536;

	typedef enum logic [2:0] {
		CFG_DEPTH_SCALE   = 3'd0,
		CFG_LATERAL_SCALE = 3'd1,
		CFG_INERTIA_RATIO = 3'd2,
		CFG_DEPTH_MIN     = 3'd3,
		CFG_DEPTH_MAX     = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic              start;
		logic [RAW_W-1:0]  dividend;
		logic [DISP_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [RAW_W-1:0] quotient;
	} div_rsp_t;

endpackage

FILE: design/sdt_divider.sv
// serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module sdt_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  sdt_pkg::div_req_t req,
	output sdt_pkg::div_rsp_t rsp
);

	localparam int CNT_W = $clog2(sdt_pkg::RAW_W);

	logic                        busy_q;
	logic                        done_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [sdt_pkg::RAW_W-1:0]   quo_q;
	logic [sdt_pkg::DISP_W-1:0]  rem_q;
	logic [sdt_pkg::DISP_W-1:0]  dsr_q;
	logic [sdt_pkg::DISP_W:0]    shifted;
	logic                        fits;

	// a zero divisor always fits, so the quotient comes out all ones
	assign shifted = {rem_q, quo_q[sdt_pkg::RAW_W-1]};
	assign fits    = shifted >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (req.start) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q  <= cnt_q + 1'b1;
				busy_q <= (cnt_q != CNT_W'(sdt_pkg::RAW_W - 1));
				done_q <= (cnt_q == CNT_W'(sdt_pkg::RAW_W - 1));
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[sdt_pkg::RAW_W-2:0], fits};
			if (fits) begin
				rem_q <= sdt_pkg::DISP_W'(shifted - {1'b0, dsr_q});
			end else begin
				rem_q <= shifted[sdt_pkg::DISP_W-1:0];
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

FILE: design/stereo_depth_triangulation.sv
// stereo depth triangulation top level: sequencer, shared multiplier and registers
// flow: an input transaction runs through the serial divider, then 7 shared multiplier
//   steps, then loads the output register
// one input is handled at a time: a new one is taken only in the idle state
// a new input is taken while the previous result waits; the final step stalls on it
// reset: clears control and outputs, loads register defaults and last depth of 200 cm
`timescale 1ns / 1ps

module stereo_depth_triangulation (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [2:0]                 cfg_index,
	input  logic [31:0]                cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [sdt_pkg::PIX_W-1:0]  left_x,
	input  logic [sdt_pkg::PIX_W-1:0]  left_y,
	input  logic [sdt_pkg::PIX_W-1:0]  right_x,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [sdt_pkg::POS_W-1:0] pos_x,
	output logic signed [sdt_pkg::POS_W-1:0] pos_y,
	output logic [sdt_pkg::DEP_W-1:0]  pos_z,
	output logic                       zero_disparity
);

	localparam int PROD_W = sdt_pkg::RAW_W + sdt_pkg::LAT_W;
	localparam int FRAC   = 25;
	localparam int MAG_W  = PROD_W - FRAC + sdt_pkg::OFF_W + 1;
	localparam int BLD_W  = sdt_pkg::INR_W + sdt_pkg::DEP_W;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DIV, ST_T, ST_QX, ST_RX, ST_QY, ST_RY, ST_W0, ST_W1, ST_FIN
	} state_t;

	state_t state_q;

	logic [sdt_pkg::RAW_W-1:0] depth_scale_q;
	logic [sdt_pkg::LAT_W-1:0] lateral_scale_q;
	logic [sdt_pkg::INR_W-1:0] inertia_q;
	logic [sdt_pkg::DEP_W-1:0] depth_min_q;
	logic [sdt_pkg::DEP_W-1:0] depth_max_q;
	logic [sdt_pkg::DEP_W-1:0] last_q;

	logic [sdt_pkg::OFF_W-1:0] hxa_q;
	logic [sdt_pkg::OFF_W-1:0] hya_q;
	logic                      hx_neg_q;
	logic                      hy_neg_q;
	logic                      zd_q;
	logic [PROD_W-1:0]         t_q;
	logic [PROD_W-1:0]         prod_q;
	logic [MAG_W-1:0]          acc_q;
	logic [sdt_pkg::DEP_W-1:0] z_q;
	logic [sdt_pkg::POS_W-1:0] px_q;
	logic [sdt_pkg::POS_W-1:0] py_q;

	logic                      out_valid_q;
	logic [sdt_pkg::POS_W-1:0] pos_x_q;
	logic [sdt_pkg::POS_W-1:0] pos_y_q;
	logic [sdt_pkg::DEP_W-1:0] pos_z_q;
	logic                      zero_q;

	sdt_pkg::div_req_t div_req;
	sdt_pkg::div_rsp_t div_rsp;

	logic                        accept;
	logic [sdt_pkg::PIX_W:0]     dx;
	logic [sdt_pkg::DISP_W-1:0]  disp;
	logic signed [sdt_pkg::OFF_W:0] hx;
	logic signed [sdt_pkg::OFF_W:0] hy;
	logic [sdt_pkg::RAW_W-1:0]   raw;
	logic [sdt_pkg::RAW_W-1:0]   lo_clamp;
	logic [sdt_pkg::DEP_W-1:0]   clamped;
	logic [sdt_pkg::INR_W-1:0]   w_eff;
	logic [sdt_pkg::RAW_W-1:0]   mul_a;
	logic [sdt_pkg::LAT_W-1:0]   mul_b;
	logic [PROD_W-1:0]           mul_p;
	logic [MAG_W-1:0]            mag;
	logic [BLD_W:0]              blend;
	logic                        fin_go;

	function automatic logic [sdt_pkg::POS_W-1:0] saturate(
		input logic [MAG_W-1:0] m,
		input logic             neg
	);
		logic [sdt_pkg::POS_W-1:0] r;
		if (neg) begin
			if (m >= MAG_W'(64'h8000_0000)) begin
				r = 32'h8000_0000;
			end else begin
				r = -m[sdt_pkg::POS_W-1:0];
			end
		end else begin
			if (m > MAG_W'(64'h7FFF_FFFF)) begin
				r = 32'h7FFF_FFFF;
			end else begin
				r = m[sdt_pkg::POS_W-1:0];
			end
		end
		return r;
	endfunction

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;

	assign dx   = {1'b0, left_x} - {1'b0, right_x};
	assign disp = dx[sdt_pkg::PIX_W] ? sdt_pkg::DISP_W'(-dx) : dx[sdt_pkg::DISP_W-1:0];
	assign hx   = $signed({1'b0, left_x, 1'b0}) - (sdt_pkg::OFF_W+1)'(sdt_pkg::IMAGE_WIDTH);
	assign hy   = $signed({1'b0, left_y, 1'b0}) - (sdt_pkg::OFF_W+1)'(sdt_pkg::IMAGE_HEIGHT);

	assign div_req.start    = accept;
	assign div_req.dividend = depth_scale_q;
	assign div_req.divisor  = disp;

	sdt_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign raw      = div_rsp.quotient;
	assign lo_clamp = (raw < {7'b0, depth_min_q}) ? {7'b0, depth_min_q} : raw;
	assign clamped  = (lo_clamp > {7'b0, depth_max_q}) ? depth_max_q
		: lo_clamp[sdt_pkg::DEP_W-1:0];
	assign w_eff    = (inertia_q > sdt_pkg::INERTIA_ONE) ? sdt_pkg::INERTIA_ONE : inertia_q;

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_T: begin
				mul_a = raw;
				mul_b = lateral_scale_q;
			end
			ST_QX: begin
				mul_a = sdt_pkg::RAW_W'(prod_q[PROD_W-1:FRAC]);
				mul_b = sdt_pkg::LAT_W'(hxa_q);
			end
			ST_RX: begin
				mul_a = sdt_pkg::RAW_W'(t_q[FRAC-1:0]);
				mul_b = sdt_pkg::LAT_W'(hxa_q);
			end
			ST_QY: begin
				mul_a = sdt_pkg::RAW_W'(t_q[PROD_W-1:FRAC]);
				mul_b = sdt_pkg::LAT_W'(hya_q);
			end
			ST_RY: begin
				mul_a = sdt_pkg::RAW_W'(t_q[FRAC-1:0]);
				mul_b = sdt_pkg::LAT_W'(hya_q);
			end
			ST_W0: begin
				mul_a = sdt_pkg::RAW_W'(last_q);
				mul_b = sdt_pkg::LAT_W'(w_eff);
			end
			ST_W1, ST_FIN: begin
				mul_a = sdt_pkg::RAW_W'(z_q);
				mul_b = sdt_pkg::LAT_W'(sdt_pkg::INERTIA_ONE - w_eff);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p  = PROD_W'(mul_a) * PROD_W'(mul_b);
	assign mag    = acc_q + MAG_W'(prod_q[PROD_W-1:FRAC]);
	assign blend  = (BLD_W+1)'(acc_q) + (BLD_W+1)'(prod_q) + (BLD_W+1)'(32768);
	assign fin_go = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			out_valid_q     <= 1'b0;
			pos_x_q         <= '0;
			pos_y_q         <= '0;
			pos_z_q         <= '0;
			zero_q          <= 1'b0;
			depth_scale_q   <= sdt_pkg::DEPTH_SCALE_RST;
			lateral_scale_q <= sdt_pkg::LATERAL_SCALE_RST;
			inertia_q       <= sdt_pkg::INERTIA_RST;
			depth_min_q     <= sdt_pkg::DEPTH_MIN_RST;
			depth_max_q     <= sdt_pkg::DEPTH_MAX_RST;
			last_q          <= sdt_pkg::LAST_DEPTH_RST;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					sdt_pkg::CFG_DEPTH_SCALE:   depth_scale_q   <= cfg_data;
					sdt_pkg::CFG_LATERAL_SCALE: lateral_scale_q <= cfg_data[sdt_pkg::LAT_W-1:0];
					sdt_pkg::CFG_INERTIA_RATIO: inertia_q       <= cfg_data[sdt_pkg::INR_W-1:0];
					sdt_pkg::CFG_DEPTH_MIN:     depth_min_q     <= cfg_data[sdt_pkg::DEP_W-1:0];
					sdt_pkg::CFG_DEPTH_MAX:     depth_max_q     <= cfg_data[sdt_pkg::DEP_W-1:0];
					default: ;
				endcase
			end
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: if (accept) state_q <= ST_DIV;
				ST_DIV:  if (div_rsp.done) state_q <= ST_T;
				ST_T:    state_q <= ST_QX;
				ST_QX:   state_q <= ST_RX;
				ST_RX:   state_q <= ST_QY;
				ST_QY:   state_q <= ST_RY;
				ST_RY:   state_q <= ST_W0;
				ST_W0:   state_q <= ST_W1;
				ST_W1:   state_q <= ST_FIN;
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
						last_q  <= blend[sdt_pkg::DEP_W+15:16];
						pos_x_q <= px_q;
						pos_y_q <= py_q;
						pos_z_q <= blend[sdt_pkg::DEP_W+15:16];
						zero_q  <= zd_q;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		if (accept) begin
			zd_q     <= (disp == '0);
			hx_neg_q <= hx[sdt_pkg::OFF_W];
			hy_neg_q <= hy[sdt_pkg::OFF_W];
			hxa_q    <= hx[sdt_pkg::OFF_W] ? sdt_pkg::OFF_W'(-hx) : hx[sdt_pkg::OFF_W-1:0];
			hya_q    <= hy[sdt_pkg::OFF_W] ? sdt_pkg::OFF_W'(-hy) : hy[sdt_pkg::OFF_W-1:0];
		end
		case (state_q)
			ST_T:  z_q   <= clamped;
			ST_QX: t_q   <= prod_q;
			ST_RX: acc_q <= MAG_W'(prod_q);
			ST_QY: px_q  <= saturate(mag, hx_neg_q);
			ST_RY: acc_q <= MAG_W'(prod_q);
			ST_W0: py_q  <= saturate(mag, hy_neg_q);
			ST_W1: acc_q <= MAG_W'(prod_q);
			default: ;
		endcase
	end

	assign out_valid      = out_valid_q;
	assign pos_x          = pos_x_q;
	assign pos_y          = pos_y_q;
	assign pos_z          = pos_z_q;
	assign zero_disparity = zero_q;

endmodule

FILE: design/sdt_checker.sv
// port level checks for the stereo depth triangulation block, with its bind
`timescale 1ns / 1ps

module sdt_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic signed [sdt_pkg::POS_W-1:0]  pos_x,
	input logic signed [sdt_pkg::POS_W-1:0]  pos_y,
	input logic [sdt_pkg::DEP_W-1:0]         pos_z,
	input logic                              zero_disparity
);

	// busy after an input transaction
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

	// a new result only appears at the end of work
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result without work");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(pos_y)
			&& $stable(pos_z) && $stable(zero_disparity))
		else $error("stalled result changed");

endmodule

bind stereo_depth_triangulation sdt_checker u_sdt_checker (.*);
